>>> sv/tcp_segmenter_retransmit_queue_top_defines.svh
// Assertion macros for the TCP segmenter and retransmit queue.
// Depends on nothing; included by the top level only.
`ifndef TCP_SEGMENTER_RETRANSMIT_QUEUE_TOP_DEFINES_SVH
`define TCP_SEGMENTER_RETRANSMIT_QUEUE_TOP_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define TSRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked during reset as well.
`define TSRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/tsrq_pkg.sv
// Shared types and constants for the TCP segmenter and retransmit queue.
// Depends on nothing.
`default_nettype none
package tsrq_pkg;
  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned MaxSendBytesDefault = 32768;
  localparam logic [15:0] MinMss = 16'd536;
  localparam logic [29:0] NsMax = 30'd999999999;
  localparam logic [30:0] NsPerSec = 31'd1000000000;
  localparam logic [7:0] FlagAck = 8'h10;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [1:0] CmdSend = 2'd0;
  localparam logic [1:0] CmdAck = 2'd1;
  localparam logic [1:0] CmdTick = 2'd2;
  localparam logic [1:0] CmdArm = 2'd3;
  localparam logic RegMss = 1'b0;
  localparam logic RegTimeout = 1'b1;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] ackno;
    logic [15:0] window;
    logic [7:0] flags;
  } entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;
endpackage
`default_nettype wire

>>> sv/tsrq_queue_mem.sv
// Retransmit queue store: one write port, one registered read port.
// Depends on tsrq_pkg.
`default_nettype none
module tsrq_queue_mem import tsrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input wire logic clk,
  input wire mem_ctl_t ctl,
  input wire logic [AW-1:0] waddr,
  input wire entry_t wdata,
  input wire logic [AW-1:0] raddr,
  output entry_t rdata
);
  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> sv/tcp_segmenter_retransmit_queue_top.sv
// TCP send side: segmentation, retransmit queue, ack and retransmit timer.
// Sequencing: a send registers its first segment from StSend once the output is free,
//   then one segment per cycle while the output is taken; an ack reads each head
//   entry examined (queue read then compare); arm or a quiet tick stays in idle.
// Flow: sequential; a transfer is taken only in idle with the output free, so a
//   new command waits until the previous one has returned to idle.
// Reset: synchronous, clears sequence, queue pointers, timer and output valid.
`default_nettype none
module tcp_segmenter_retransmit_queue_top import tsrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned MAX_SEND_BYTES = MaxSendBytesDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [15:0] cfg_data,
  input wire logic s_tvalid,
  output logic s_tready,
  // tdata from bit 0: byte_count[15:0], tcp_flags[23:16], keep_for_retransmit[24],
  // advertised_window[40:25], recv_next[72:41], peer_ack[104:73],
  // delta_ns[134:105], zero fill to 136
  input wire logic [135:0] s_tdata,
  input wire logic [1:0] s_tuser, // cmd
  output logic m_tvalid,
  input wire logic m_tready,
  // tdata from bit 0: seg_seq_out[31:0], seg_ack_out[63:32], seg_length[79:64],
  // seg_window[95:80], seg_flags[103:96], zero fill to 104
  output logic [103:0] m_tdata,
  // tuser from bit 0: is_retransmit, queue_dropped, timeout_seen
  output logic [2:0] m_tuser,
  output logic m_tlast
);
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] MaxSend = 16'(MAX_SEND_BYTES > 65535 ? 65535 : MAX_SEND_BYTES);
  localparam logic [CW-1:0] Depth = CW'(QUEUE_DEPTH);
  localparam logic [AW:0] DepthW = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSend = 3'd1;
  localparam logic [2:0] StAckRd = 3'd2;
  localparam logic [2:0] StAckCmp = 3'd3;
  localparam logic [2:0] StTickRd = 3'd4;
  localparam logic [2:0] StTickOut = 3'd5;

  logic [2:0] state;
  logic [15:0] mss_reg, timeout_reg;
  logic [31:0] next_seq;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [29:0] ns_acc;
  logic [15:0] secs;
  logic armed, timed_out;

  // latched command
  logic [15:0] remain;
  logic zero_send;
  logic [7:0] c_flags;
  logic c_keep;
  logic [15:0] c_wnd;
  logic [31:0] c_ack;

  entry_t wdata, rdata;
  mem_ctl_t ctl;
  logic [AW-1:0] waddr;

  tsrq_queue_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata), .raddr(head), .rdata(rdata)
  );

  // in_bits fields
  logic [15:0] in_bytes;
  logic [15:0] mss;
  logic out_free;
  assign in_bytes = s_tdata[15:0];
  assign mss = (mss_reg < MinMss) ? MinMss : mss_reg;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == StIdle) && out_free;

  // current send segment
  logic last_seg;
  logic [15:0] seg_size;
  logic [7:0] seg_flags;
  logic [31:0] seg_ack;
  logic room;
  logic [AW:0] tail_sum;
  logic [AW-1:0] tail;
  logic send_we;
  logic emit;
  assign last_seg = (remain <= mss);
  assign seg_size = last_seg ? remain : mss;
  assign seg_flags = (last_seg && !zero_send) ? (c_flags | FlagPsh) : c_flags;
  assign seg_ack = ((c_flags & FlagAck) != 8'd0) ? c_ack : 32'd0;
  assign room = (count != Depth);
  // tail slot: head plus count, wrapped at the queue depth
  assign tail_sum = (AW+1)'(head) + (AW+1)'(count);
  assign tail = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : AW'(tail_sum);
  assign send_we = (state == StSend) && out_free && c_keep && room;
  assign emit = ((state == StSend) || (state == StTickOut)) && out_free;

  // ack arithmetic
  logic [31:0] end_seq;
  logic [31:0] ack_val;
  assign ack_val = c_ack;
  assign end_seq = rdata.seq + 32'(rdata.len);

  // trim a partly acknowledged head: rewrite it in the free write slot
  logic trim_we;
  assign trim_we = (state == StAckRd) && !(end_seq <= ack_val) && (ack_val >= rdata.seq);

  entry_t trim_data;
  always_comb begin
    trim_data = rdata;
    trim_data.seq = ack_val;
    trim_data.len = rdata.len - 16'(ack_val - rdata.seq);
  end

  always_comb begin
    wdata.seq = next_seq;
    wdata.len = seg_size;
    wdata.ackno = seg_ack;
    wdata.window = c_wnd;
    wdata.flags = seg_flags;
    waddr = tail;
    if (trim_we) begin
      wdata = trim_data;
      waddr = head;
    end
    ctl.we = send_we || trim_we;
    ctl.re = (s_tvalid && s_tready && (s_tuser == CmdAck || s_tuser == CmdTick))
             || (state == StAckCmp);
  end

  // tick arithmetic
  logic [29:0] dns;
  logic [30:0] ns_sum;
  assign dns = (s_tdata[134:105] > NsMax) ? NsMax : s_tdata[134:105];
  assign ns_sum = 31'(ns_acc) + 31'(dns);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      mss_reg <= MinMss;
      timeout_reg <= 16'd10;
      next_seq <= '0;
      head <= '0;
      count <= '0;
      ns_acc <= '0;
      secs <= '0;
      armed <= 1'b0;
      timed_out <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegMss: mss_reg <= cfg_data;
          RegTimeout: timeout_reg <= cfg_data;
          default: ;
        endcase
      end
      // drop valid once taken, unless a new transfer replaces it
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (s_tvalid && s_tready) begin
            c_flags <= s_tdata[23:16];
            c_keep <= s_tdata[24];
            c_wnd <= s_tdata[40:25];
            unique case (s_tuser)
              CmdSend: begin
                remain <= (in_bytes > MaxSend) ? MaxSend : in_bytes;
                zero_send <= (in_bytes == 16'd0);
                c_ack <= s_tdata[72:41];
                state <= StSend;
              end
              CmdAck: begin
                c_ack <= s_tdata[104:73];
                if (count != '0) begin
                  state <= StAckCmp;
                end
              end
              CmdTick: begin
                // advance the timer now; the queue head is read meanwhile
                if (armed && secs < timeout_reg) begin
                  if (ns_sum >= NsPerSec) begin
                    ns_acc <= 30'(ns_sum - NsPerSec);
                    if (secs + 16'd1 >= timeout_reg) begin
                      armed <= 1'b0;
                      timed_out <= 1'b1;
                      secs <= secs + 16'd1;
                      if (count != '0) state <= StTickOut;
                    end else begin
                      secs <= secs + 16'd1;
                    end
                  end else begin
                    ns_acc <= 30'(ns_sum);
                  end
                end
              end
              default: begin
                armed <= 1'b1;
                secs <= '0;
                ns_acc <= '0;
                timed_out <= 1'b0;
              end
            endcase
          end
        end
        StSend: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= {seg_flags, c_wnd, seg_size, seg_ack, next_seq};
            m_tuser <= {timed_out, c_keep && !room, 1'b0};
            m_tlast <= last_seg;
            next_seq <= next_seq + 32'(seg_size);
            if (c_keep && room) count <= count + CW'(1);
            remain <= remain - seg_size;
            if (last_seg) state <= StIdle;
          end
        end
        StAckCmp: begin
          // read the head entry into rdata for the compare in StAckRd
          state <= StAckRd;
        end
        StAckRd: begin
          if (end_seq <= ack_val) begin
            head <= (head == LastSlot) ? '0 : head + AW'(1);
            count <= count - CW'(1);
            state <= (count == CW'(1)) ? StIdle : StAckCmp;
          end else begin
            state <= StIdle;
          end
        end
        StTickOut: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= {rdata.flags, rdata.window, rdata.len,
                        ((rdata.flags & FlagAck) != 8'd0) ? rdata.ackno : 32'd0, rdata.seq};
            m_tuser <= 3'b001;
            m_tlast <= 1'b1;
            secs <= '0;
            ns_acc <= '0;
            timed_out <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  `include "tcp_segmenter_retransmit_queue_top_defines.svh"

  `TSRQ_ASSERT(a_count_bound, count <= Depth, "queue count above depth")
  `TSRQ_ASSERT(a_busy_no_accept, state != StIdle |-> !s_tready, "accept while busy")
  `TSRQ_ASSERT_ALWAYS(a_reset_idle, rst |=> state == StIdle && !m_tvalid, "reset not idle")
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the TCP segmenter and retransmit queue.
// Drives command transfers, predicts segment descriptors and checks them in order.
// Depends on tsrq_pkg and tcp_segmenter_retransmit_queue_top.
`default_nettype none
module tb import tsrq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned MaxSend = 32768;
  localparam int unsigned LimitCycles = 1500000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] byte_count;
    logic [7:0]  tcp_flags;
    logic        keep;
    logic [15:0] window;
    logic [31:0] recv_next;
    logic [31:0] peer_ack;
    logic [29:0] delta_ns;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ackno;
    logic [15:0] len;
    logic [15:0] window;
    logic [7:0]  flags;
    logic        retx;
    logic        dropped;
    logic        timeout;
    logic        last;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  tcp_segmenter_retransmit_queue_top u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #5 clk = ~clk;

  // Mirror of the block's state and registers
  logic [15:0] mss_reg, timeout_reg;
  logic [31:0] snd_next;
  entry_t      rtx_q [Depth];
  int unsigned rtx_head, rtx_count;
  logic [30:0] ns_accum;
  logic [15:0] secs;
  logic        armed, timed_out;

  cmd_item_t   pending_cmds[$];
  segment_t    expected_segs[$];
  int unsigned errors = 0;
  int unsigned cycle = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  // Record the input acceptance at the rising edge for the driver.
  logic s_tready_seen = 1'b0;
  always @(posedge clk) s_tready_seen <= s_tvalid && s_tready;

  task automatic report(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle, what);
    errors++;
  endtask

  // Work out the descriptors one command causes and update the mirror.
  function automatic void predict_segments(input cmd_item_t c);
    segment_t outs[$];
    segment_t s;
    logic [31:0] n, off, sz, mss, seq_end;
    logic [7:0] fl;
    int unsigned slot;
    logic done;
    fl = c.tcp_flags;
    case (c.cmd)
      CmdSend: begin
        mss = 32'((mss_reg < MinMss) ? MinMss : mss_reg);
        n = (32'(c.byte_count) > MaxSend) ? MaxSend : 32'(c.byte_count);
        off = 0;
        do begin
          sz = mss;
          if (off + sz >= n) begin
            sz = n - off;
            if (n != 0) fl = fl | FlagPsh;
          end
          s = '0;
          s.seq = snd_next;
          snd_next = snd_next + sz;
          s.ackno = ((fl & FlagAck) != 8'd0) ? c.recv_next : 32'd0;
          s.len = sz[15:0];
          s.window = c.window;
          s.flags = fl;
          if (c.keep) begin
            if (rtx_count < Depth) begin
              slot = (rtx_head + rtx_count) % Depth;
              rtx_q[slot] = '{s.seq, s.len, s.ackno, s.window, s.flags};
              rtx_count++;
            end else s.dropped = 1'b1;
          end
          outs.push_back(s);
          off = off + mss;
        end while (off < ((n == 0) ? 32'd1 : n));
      end
      CmdAck: begin
        done = 1'b0;
        while (rtx_count != 0 && !done) begin
          seq_end = rtx_q[rtx_head].seq + 32'(rtx_q[rtx_head].len);
          if (seq_end <= c.peer_ack) begin
            rtx_head = (rtx_head + 1) % Depth;
            rtx_count--;
          end else begin
            if (c.peer_ack >= rtx_q[rtx_head].seq) begin
              rtx_q[rtx_head].len = rtx_q[rtx_head].len -
                                    16'(c.peer_ack - rtx_q[rtx_head].seq);
              rtx_q[rtx_head].seq = c.peer_ack;
            end
            done = 1'b1;
          end
        end
      end
      CmdTick: begin
        if (armed && secs < timeout_reg) begin
          ns_accum = ns_accum + 31'((c.delta_ns > NsMax) ? NsMax : c.delta_ns);
          if (ns_accum >= NsPerSec) begin
            secs++;
            ns_accum = ns_accum - NsPerSec;
          end
          if (secs >= timeout_reg) begin
            armed = 1'b0;
            timed_out = 1'b1;
            if (rtx_count != 0) begin
              s = '0;
              s.seq = rtx_q[rtx_head].seq;
              s.flags = rtx_q[rtx_head].flags;
              s.ackno = ((s.flags & FlagAck) != 8'd0) ? rtx_q[rtx_head].ackno : 32'd0;
              s.len = rtx_q[rtx_head].len;
              s.window = rtx_q[rtx_head].window;
              s.retx = 1'b1;
              outs.push_back(s);
              secs = 0;
              ns_accum = 0;
              timed_out = 1'b0;
            end
          end
        end
      end
      default: begin
        armed = 1'b1;
        secs = 0;
        ns_accum = 0;
        timed_out = 1'b0;
      end
    endcase
    foreach (outs[i]) begin
      outs[i].timeout = timed_out;
      outs[i].last = (i == outs.size() - 1);
      expected_segs.push_back(outs[i]);
    end
  endfunction

  // Driver: offer the oldest pending command, change on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (pending_cmds.size() > 0 && (!s_tvalid || s_tready_seen) &&
          $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_cmds[0].cmd;
        s_tdata <= {1'b0, pending_cmds[0].delta_ns, pending_cmds[0].peer_ack,
                    pending_cmds[0].recv_next, pending_cmds[0].window,
                    pending_cmds[0].keep, pending_cmds[0].tcp_flags,
                    pending_cmds[0].byte_count};
        predict_segments(pending_cmds.pop_front());
      end else if (s_tvalid && s_tready_seen) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold counted down here.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every accepted descriptor with the oldest expectation.
  always @(posedge clk) begin
    segment_t want;
    cycle <= cycle + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_segs.size() == 0) report("descriptor with none expected");
      else begin
        want = expected_segs.pop_front();
        if (m_tdata[31:0] !== want.seq)
          report($sformatf("seq %h want %h", m_tdata[31:0], want.seq));
        if (m_tdata[63:32] !== want.ackno)
          report($sformatf("ack %h want %h", m_tdata[63:32], want.ackno));
        if (m_tdata[79:64] !== want.len)
          report($sformatf("len %0d want %0d", m_tdata[79:64], want.len));
        if (m_tdata[95:80] !== want.window)
          report($sformatf("window %h want %h", m_tdata[95:80], want.window));
        if (m_tdata[103:96] !== want.flags)
          report($sformatf("flags %h want %h", m_tdata[103:96], want.flags));
        if (m_tuser !== {want.timeout, want.dropped, want.retx})
          report($sformatf("tuser %b want %b", m_tuser,
                           {want.timeout, want.dropped, want.retx}));
        if (m_tlast !== want.last)
          report($sformatf("tlast %b want %b", m_tlast, want.last));
      end
    end
    if (cycle > LimitCycles) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic cmd_item_t rand_cmd(input logic [1:0] cmd);
    cmd_item_t c;
    c.cmd = cmd;
    // Mostly small sends, now and then a large one or one past the cap
    case ($urandom_range(9))
      0: c.byte_count = 16'($urandom_range(32769, 65535));
      1: c.byte_count = 16'($urandom_range(4000, 32768));
      2: c.byte_count = 16'd0;
      default: c.byte_count = 16'($urandom_range(1, 1800));
    endcase
    c.tcp_flags = 8'($urandom);
    c.keep = ($urandom_range(3) != 0);
    c.window = 16'($urandom);
    c.recv_next = $urandom;
    c.peer_ack = $urandom;
    c.delta_ns = ($urandom_range(9) == 0) ? 30'($urandom) :
                 30'($urandom_range(300000000, 999999999));
    return c;
  endfunction

  // Ack near the queue: whole entries, inside one, or ahead of it.
  function automatic logic [31:0] near_ack();
    logic [31:0] base;
    base = (rtx_count != 0) ? rtx_q[rtx_head].seq : snd_next;
    case ($urandom_range(4))
      0: return base - 32'($urandom_range(1, 100));
      1: return base + 32'($urandom_range(0, 600));
      2: return snd_next;
      3: return base + 32'($urandom_range(0, 6000));
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_tvalid || expected_segs.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegMss) mss_reg = val; else timeout_reg = val;
  endtask

  // Queue one phase of random commands; sends and acks mostly, with ticks and arms.
  task automatic add_random(input int unsigned count);
    cmd_item_t c;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: c = rand_cmd(CmdSend);
        4, 5: begin c = rand_cmd(CmdAck); c.peer_ack = near_ack(); end
        6, 7, 8: c = rand_cmd(CmdTick);
        default: c = rand_cmd(CmdArm);
      endcase
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    cmd_item_t c;
    mss_reg = 16'd536; timeout_reg = 16'd10;
    snd_next = 0; rtx_head = 0; rtx_count = 0;
    ns_accum = 0; secs = 0; armed = 0; timed_out = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty send, PSH, cap, full queue, acks, ticks and timeouts
    c = rand_cmd(CmdSend); c.byte_count = 0; c.tcp_flags = 8'h10; c.keep = 1;
    pending_cmds.push_back(c);
    c = rand_cmd(CmdSend); c.byte_count = 16'hFFFF; c.tcp_flags = 8'h00; c.keep = 1;
    pending_cmds.push_back(c);
    c = rand_cmd(CmdSend); c.byte_count = 536; c.tcp_flags = 8'hFF; c.keep = 1;
    pending_cmds.push_back(c);
    c = rand_cmd(CmdAck); c.peer_ack = 32'd100; pending_cmds.push_back(c);
    c = rand_cmd(CmdAck); c.peer_ack = 32'd1072; pending_cmds.push_back(c);
    c = rand_cmd(CmdTick); pending_cmds.push_back(c);
    c = rand_cmd(CmdArm); pending_cmds.push_back(c);
    repeat (12) begin
      c = rand_cmd(CmdTick); c.delta_ns = 30'h3FFFFFFF; pending_cmds.push_back(c);
    end
    c = rand_cmd(CmdAck); c.peer_ack = 32'hFFFFFFFF; pending_cmds.push_back(c);
    c = rand_cmd(CmdArm); pending_cmds.push_back(c);
    repeat (11) begin
      c = rand_cmd(CmdTick); c.delta_ns = 30'd0; pending_cmds.push_back(c);
    end
    wait_drained();

    write_reg(RegMss, 16'd0);
    write_reg(RegTimeout, 16'd1);
    add_random(100);
    wait_drained();

    write_reg(RegMss, 16'hFFFF);
    write_reg(RegTimeout, 16'd0);
    send_idle_pct = 79;
    add_random(90);
    wait_drained();

    write_reg(RegMss, 16'd1460);
    write_reg(RegTimeout, 16'hFFFF);
    send_idle_pct = 0; recv_stall_pct = 79;
    add_random(90);
    wait_drained();

    write_reg(RegMss, 16'd536);
    write_reg(RegTimeout, 16'd2);
    send_idle_pct = 25; recv_stall_pct = 25;
    add_random(90);
    wait_drained();

    // Hold off the receiver while the sender keeps offering transfers
    send_idle_pct = 0; recv_stall_pct = 0;
    write_reg(RegMss, 16'd700);
    add_random(70);
    hold_cycles = 3000;
    wait_drained();

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
